[hw/rtl/lobdu_pkg.sv]
package lobdu_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHARED    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POS_WRITE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEG_WRITE = 3'd5;

  // Reset values.
  localparam logic [15:0] HOLDOFF_RESET   = 16'd100;
  localparam logic        SHARED_RESET    = 1'b1;
  localparam logic [7:0]  STOP_RESET      = 8'd17;
  localparam logic [7:0]  START_RESET     = 8'd16;
  localparam logic [7:0]  POS_WRITE_RESET = 8'd77;
  localparam logic [7:0]  NEG_WRITE_RESET = 8'd78;
  localparam logic [7:0]  FLAGS_RESET     = 8'hFF;
  localparam logic [15:0] COUNTER_MAX     = 16'hFFFF;
  localparam logic [7:0]  ZERO_BYTE       = 8'h00;

  // Depth of the queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Byte slots of one update run.
  localparam int unsigned SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_STOP      = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_POS_OP    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_POS_ZERO  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_POS_DATA  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_NEG_OP    = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_NEG_ZERO  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_NEG_DATA  = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_START     = 3'd7;

  typedef struct packed {
    logic [15:0] holdoff_samples;
    logic        shared_negative;
    logic [7:0]  stop_command;
    logic [7:0]  start_command;
    logic [7:0]  pos_select_write_opcode;
    logic [7:0]  neg_select_write_opcode;
  } cfg_t;

  // One pending update: the flags as received.
  typedef struct packed {
    logic [7:0] pos_flags;
    logic [7:0] neg_raw_flags;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hw/rtl/lobdu_status_if.sv]
interface lobdu_status_if;
  logic        valid;
  logic        ready;
  logic [23:0] status_word;

  modport source (output valid, output status_word, input ready);
  modport sink (input valid, input status_word, output ready);
endinterface

[hw/rtl/lobdu_spi_if.sv]
interface lobdu_spi_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       end_of_transfer;
  logic       last;

  modport source (output valid, output spi_byte, output end_of_transfer, output last,
                  input ready);
  modport sink (input valid, input spi_byte, input end_of_transfer, input last,
                output ready);
endinterface

[hw/rtl/lobdu_front.sv]
module lobdu_front (
  input  logic                  clk,
  input  logic                  rst,
  input  lobdu_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [23:0]           status_word,
  input  lobdu_pkg::queue_status_t q_status,
  output logic                  push,
  output lobdu_pkg::job_t       push_job
);

  logic [7:0]  prev_pos_flags;
  logic [7:0]  prev_neg_flags;
  logic [15:0] frames_since_change;

  logic [7:0] pos;
  logic [7:0] neg_raw;
  logic [7:0] neg;
  logic       fire;
  logic       accept;

  assign pos     = status_word[19:12];
  assign neg_raw = status_word[11:4];
  assign neg     = neg_raw | {7'd0, cfg.shared_negative};

  assign fire = (frames_since_change >= cfg.holdoff_samples) &&
                ((pos != prev_pos_flags) || (neg != prev_neg_flags));

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign push                   = accept && fire;
  assign push_job.pos_flags     = pos;
  assign push_job.neg_raw_flags = neg_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos_flags      <= lobdu_pkg::FLAGS_RESET;
      prev_neg_flags      <= lobdu_pkg::FLAGS_RESET;
      frames_since_change <= '0;
    end else if (accept) begin
      if (fire) begin
        prev_pos_flags      <= pos;
        prev_neg_flags      <= neg;
        frames_since_change <= '0;
      end else if (frames_since_change != lobdu_pkg::COUNTER_MAX) begin
        frames_since_change <= frames_since_change + 16'd1;
      end
    end
  end

endmodule

[hw/rtl/lobdu_queue.sv]
module lobdu_queue #(
  parameter int unsigned DEPTH = lobdu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  lobdu_pkg::job_t          push_job,
  input  logic                     pop,
  output lobdu_pkg::job_t          head,
  output lobdu_pkg::queue_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lobdu_pkg::job_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/lobdu_back.sv]
module lobdu_back (
  input  logic                     clk,
  input  logic                     rst,
  input  lobdu_pkg::cfg_t          cfg,
  input  lobdu_pkg::job_t          head,
  input  lobdu_pkg::queue_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               spi_byte,
  output logic                     end_of_transfer,
  output logic                     last
);

  logic [lobdu_pkg::SLOT_W-1:0] slot;
  logic                         out_accept;

  assign out_valid  = !q_status.empty;
  assign out_accept = out_valid && out_ready;
  assign pop        = out_accept && (slot == lobdu_pkg::SLOT_START);

  always_comb begin
    spi_byte        = lobdu_pkg::ZERO_BYTE;
    end_of_transfer = 1'b0;
    last            = 1'b0;
    case (slot)
      lobdu_pkg::SLOT_STOP: begin
        spi_byte        = cfg.stop_command;
        end_of_transfer = 1'b1;
      end
      lobdu_pkg::SLOT_POS_OP: begin
        spi_byte = cfg.pos_select_write_opcode;
      end
      lobdu_pkg::SLOT_POS_ZERO: begin
        spi_byte = lobdu_pkg::ZERO_BYTE;
      end
      lobdu_pkg::SLOT_POS_DATA: begin
        spi_byte        = ~head.pos_flags;
        end_of_transfer = 1'b1;
      end
      lobdu_pkg::SLOT_NEG_OP: begin
        spi_byte = cfg.neg_select_write_opcode;
      end
      lobdu_pkg::SLOT_NEG_ZERO: begin
        spi_byte = lobdu_pkg::ZERO_BYTE;
      end
      lobdu_pkg::SLOT_NEG_DATA: begin
        spi_byte        = ~head.neg_raw_flags;
        end_of_transfer = 1'b1;
      end
      lobdu_pkg::SLOT_START: begin
        spi_byte        = cfg.start_command;
        end_of_transfer = 1'b1;
        last            = 1'b1;
      end
      default: begin
        spi_byte = lobdu_pkg::ZERO_BYTE;
      end
    endcase
  end

  // The slot wraps to the stop byte after the start byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= lobdu_pkg::SLOT_STOP;
    end else if (out_accept) begin
      slot <= slot + lobdu_pkg::SLOT_W'(1);
    end
  end

endmodule

[hw/rtl/lead_off_bias_drive_updater.sv]
// Lead-off bias drive updater. Each item on the status channel is the 24-bit
// status word of one converter frame; bits 19:12 carry the positive lead-off
// flags and bits 11:4 the negative ones. When at least holdoff_samples frames
// have gone by since the last update and the flags differ from the stored
// copy (negative bit 0 forced high first in shared-negative mode), the block
// sends an eight-item run on the SPI channel: stop, positive bias select
// write with the inverted positive flags, negative bias select write with the
// inverted negative flags as received, and start. A status item that causes
// no update is taken back-to-back while the queue has room. An update run
// leaves at one byte per cycle while the SPI side keeps ready high, as the
// back end walks one byte slot per cycle, while ready is high, over the
// head of the update queue. The front end decides on each frame as it
// arrives and keeps taking status items while the queue (two pending updates
// by default) has room, so a slow SPI side only holds off the status channel
// once the queue is full. Configuration registers are written through
// cfg_we, cfg_index and cfg_data, and should only be changed while no update
// run is pending.
module lead_off_bias_drive_updater #(
  parameter int unsigned QUEUE_DEPTH = lobdu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lobdu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lobdu_pkg::CFG_DATA_W-1:0]  cfg_data,
  lobdu_status_if.sink                      status,
  lobdu_spi_if.source                       spi
);

  lobdu_pkg::cfg_t          cfg;
  lobdu_pkg::queue_status_t q_status;
  lobdu_pkg::job_t          push_job;
  lobdu_pkg::job_t          head;
  logic                     push;
  logic                     pop;

  // Configuration registers; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.holdoff_samples         <= lobdu_pkg::HOLDOFF_RESET;
      cfg.shared_negative         <= lobdu_pkg::SHARED_RESET;
      cfg.stop_command            <= lobdu_pkg::STOP_RESET;
      cfg.start_command           <= lobdu_pkg::START_RESET;
      cfg.pos_select_write_opcode <= lobdu_pkg::POS_WRITE_RESET;
      cfg.neg_select_write_opcode <= lobdu_pkg::NEG_WRITE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lobdu_pkg::CFG_HOLDOFF:   cfg.holdoff_samples         <= cfg_data;
        lobdu_pkg::CFG_SHARED:    cfg.shared_negative         <= cfg_data[0];
        lobdu_pkg::CFG_STOP:      cfg.stop_command            <= cfg_data[7:0];
        lobdu_pkg::CFG_START:     cfg.start_command           <= cfg_data[7:0];
        lobdu_pkg::CFG_POS_WRITE: cfg.pos_select_write_opcode <= cfg_data[7:0];
        lobdu_pkg::CFG_NEG_WRITE: cfg.neg_select_write_opcode <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: classifies each frame and updates the stored flags.
  lobdu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (status.valid),
    .in_ready    (status.ready),
    .status_word (status.status_word),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  // Pending updates waiting for the SPI side.
  lobdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: turns the head update into its eight SPI bytes.
  lobdu_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (spi.valid),
    .out_ready       (spi.ready),
    .spi_byte        (spi.spi_byte),
    .end_of_transfer (spi.end_of_transfer),
    .last            (spi.last)
  );

endmodule

[hw/rtl/lobdu_checker.sv]
module lobdu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] spi_byte,
  input logic       end_of_transfer,
  input logic       last
);

  // A byte offered and not taken stays on offer unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(spi_byte) &&
                                $stable(end_of_transfer) && $stable(last))
    else $error("SPI item changed while stalled");

  // The final byte of a run always releases chip select.
  a_last_eot: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> end_of_transfer)
    else $error("last byte without end of transfer");

  // Reset empties the update queue.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("SPI item offered straight after reset");

  // A byte that keeps chip select low is never the final one, and once it is
  // taken the next byte is on offer and is not the final one either.
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !end_of_transfer |=> out_valid && !last)
    else $error("run ended straight after a byte that holds chip select");

endmodule

bind lead_off_bias_drive_updater lobdu_checker u_lobdu_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (spi.valid),
  .out_ready       (spi.ready),
  .spi_byte        (spi.spi_byte),
  .end_of_transfer (spi.end_of_transfer),
  .last            (spi.last)
);
